FILE: rtl/fdr_pkg.sv
// ----------------------------------------------------------------------------
// fdr_pkg
// Types and constants of the dielectric Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fdr_pkg;

	// Configuration register indexes.
	typedef enum logic {
		REG_ETA_INCIDENT    = 1'b0,
		REG_ETA_TRANSMITTED = 1'b1
	} cfg_reg_t;

	localparam int unsigned ETA_W    = 16;  // Q4.12 index
	localparam int unsigned COS_W    = 16;  // Q2.14 cosine
	localparam int unsigned CMAG_W   = 15;  // magnitude of the clamped cosine
	localparam int unsigned TRIG_W   = 31;  // Q.30 sine or cosine, up to 1.0
	localparam int unsigned ST_W     = 30;  // Q.30 sine below 1.0
	localparam int unsigned PROD_W   = 47;  // index times Q.30 value
	localparam int unsigned DEN_W    = 48;  // sum of two products
	localparam int unsigned RATIO_W  = 17;  // Q.16 ratio, up to 1.0
	localparam int unsigned REFL_W   = 16;  // Q1.15 result

	localparam logic [ETA_W-1:0]  ETA_INCIDENT_RST    = 16'd4096;
	localparam logic [ETA_W-1:0]  ETA_TRANSMITTED_RST = 16'd6144;
	localparam logic signed [16:0] COS_MAX = 17'sd16384;
	localparam logic signed [16:0] COS_MIN = -17'sd16384;
	localparam logic [REFL_W-1:0] REFL_ONE = 16'd32768;
	localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

	typedef struct packed {
		logic              swap;
		logic [CMAG_W-1:0] cmag;
		logic              tir;
	} item_side_t;

endpackage

FILE: rtl/fdr_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// fdr_sqrt_pipe
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module fdr_sqrt_pipe #(
	parameter int unsigned RES_W  = 31,
	parameter int unsigned SIDE_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2*RES_W-1:0]    radicand,
	input  logic [SIDE_W-1:0]     in_side,
	output logic                  out_valid,
	output logic [RES_W-1:0]      root,
	output logic [SIDE_W-1:0]     out_side
);

	localparam int unsigned RW = 2 * RES_W + 1;

	logic              valid_s [0:RES_W];
	logic [RW-1:0]     rem_s   [0:RES_W];
	logic [RES_W-1:0]  root_s  [0:RES_W];
	logic [SIDE_W-1:0] side_s  [0:RES_W];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = {1'b0, radicand};
	assign root_s[0]  = '0;
	assign side_s[0]  = in_side;

	// Stage i decides result bit RES_W-1-i from the running remainder.
	for (genvar i = 0; i < RES_W; i++) begin : g_stage
		localparam int unsigned K = RES_W - 1 - i;
		logic [RW-1:0] trial;
		logic          take;

		assign trial = (RW'(root_s[i]) << (K + 1)) | (RW'(1) << (2 * K));
		assign take  = rem_s[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? rem_s[i] - trial : rem_s[i];
				root_s[i+1] <= take ? (root_s[i] | (RES_W'(1) << K)) : root_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = valid_s[RES_W];
	assign root      = root_s[RES_W];
	assign out_side  = side_s[RES_W];

endmodule

FILE: rtl/fdr_div_pipe.sv
// ----------------------------------------------------------------------------
// fdr_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module fdr_div_pipe #(
	parameter int unsigned N_W    = 47,
	parameter int unsigned D_W    = 16,
	parameter int unsigned Q_W    = 30,
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [N_W-1:0]    dividend,
	input  logic [D_W-1:0]    divisor,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [Q_W-1:0]    quotient,
	output logic [SIDE_W-1:0] out_side
);

	// The quotient is exact when the dividend is below divisor times 2^Q_W.
	localparam int unsigned WW = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

	logic              valid_s [0:Q_W];
	logic [WW-1:0]     rem_s   [0:Q_W];
	logic [D_W-1:0]    dvs_s   [0:Q_W];
	logic [Q_W-1:0]    quo_s   [0:Q_W];
	logic [SIDE_W-1:0] side_s  [0:Q_W];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = WW'(dividend);
	assign dvs_s[0]   = divisor;
	assign quo_s[0]   = '0;
	assign side_s[0]  = in_side;

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		localparam int unsigned K = Q_W - 1 - i;
		logic [WW-1:0] trial;
		logic          take;

		assign trial = WW'(dvs_s[i]) << K;
		assign take  = rem_s[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? rem_s[i] - trial : rem_s[i];
				quo_s[i+1]  <= take ? (quo_s[i] | (Q_W'(1) << K)) : quo_s[i];
				dvs_s[i+1]  <= dvs_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = valid_s[Q_W];
	assign quotient  = quo_s[Q_W];
	assign out_side  = side_s[Q_W];

endmodule

FILE: rtl/fresnel_dielectric_reflectance.sv
// Throughput: one item per cycle; every stage advances unless the output
// register holds a result whose transfer is stalled.
// The depth is set by two 31-stage square roots and dividers of 30 and 17 stages.
// Reset clears all valid bits and loads the index registers with 1.0 and 1.5.
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarized Fresnel reflectance of a dielectric interface in fixed point.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [fdr_pkg::COS_W-1:0] cos_theta,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [fdr_pkg::REFL_W-1:0]     reflectance,
	output logic                           total_internal,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [fdr_pkg::ETA_W-1:0]      cfg_data
);

	import fdr_pkg::*;

	localparam int unsigned SIDE_W = $bits(item_side_t);

	logic             en;
	logic [ETA_W-1:0] eta_inc_q, eta_trn_q;

	// The whole pipeline moves unless the finished result is held.
	assign en        = !(out_valid && out_stall);
	assign in_stall  = out_valid && out_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_inc_q <= ETA_INCIDENT_RST;
			eta_trn_q <= ETA_TRANSMITTED_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ETA_INCIDENT:    eta_inc_q <= cfg_data;
				REG_ETA_TRANSMITTED: eta_trn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A zero index counts as one LSB; the swap flag exchanges the two sides.
	logic [ETA_W-1:0] eta_inc_fix, eta_trn_fix;
	assign eta_inc_fix = (eta_inc_q == '0) ? ETA_W'(1) : eta_inc_q;
	assign eta_trn_fix = (eta_trn_q == '0) ? ETA_W'(1) : eta_trn_q;

	// Stage 1: clamp the cosine, pick the side and take its magnitude.
	logic signed [16:0] cos_ext, cos_clamp;
	logic               valid_s1, swap_s1;
	logic [CMAG_W-1:0]  cmag_s1;

	assign cos_ext   = 17'(cos_theta);
	assign cos_clamp = (cos_ext > COS_MAX) ? COS_MAX :
	                   (cos_ext < COS_MIN) ? COS_MIN : cos_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			swap_s1 <= cos_clamp <= 17'sd0;
			cmag_s1 <= (cos_clamp < 17'sd0) ? CMAG_W'(-cos_clamp) : CMAG_W'(cos_clamp);
		end
	end

	// Stage 2: one minus the squared cosine, Q.28.
	logic             valid_s2;
	logic [28:0]      rad_s2;
	item_side_t       side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2       <= 29'(29'd1 << 28) - 29'(30'(cmag_s1) * 30'(cmag_s1));
			side_s2.swap <= swap_s1;
			side_s2.cmag <= cmag_s1;
			side_s2.tir  <= 1'b0;
		end
	end

	// Sine of incidence, Q.30.
	logic              si_valid;
	logic [TRIG_W-1:0] si;
	item_side_t        si_side;

	fdr_sqrt_pipe #(.RES_W(TRIG_W), .SIDE_W(SIDE_W)) u_sqrt_sin (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s2),
		.radicand({1'b0, rad_s2, 32'd0}),
		.in_side(side_s2),
		.out_valid(si_valid), .root(si), .out_side(si_side)
	);

	// Stage 3: scale by the incident index.
	logic              valid_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [ETA_W-1:0]  et_s3;
	item_side_t        side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= si_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PROD_W'(si) * PROD_W'(si_side.swap ? eta_trn_fix : eta_inc_fix);
			et_s3   <= si_side.swap ? eta_inc_fix : eta_trn_fix;
			side_s3 <= si_side;
		end
	end

	// Stage 4: total internal reflection when the product reaches eta_t * 1.0.
	logic              valid_s4;
	logic [PROD_W-1:0] prod_s4;
	logic [ETA_W-1:0]  et_s4;
	item_side_t        side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4      <= prod_s3;
			et_s4        <= et_s3;
			side_s4.swap <= side_s3.swap;
			side_s4.cmag <= side_s3.cmag;
			side_s4.tir  <= prod_s3 >= (PROD_W'(et_s3) << ST_W);
		end
	end

	// Sine of transmission, Q.30.
	logic            st_valid;
	logic [ST_W-1:0] st;
	item_side_t      st_side;

	fdr_div_pipe #(.N_W(PROD_W), .D_W(ETA_W), .Q_W(ST_W), .SIDE_W(SIDE_W)) u_div_sin (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s4), .dividend(prod_s4), .divisor(et_s4),
		.in_side(side_s4),
		.out_valid(st_valid), .quotient(st), .out_side(st_side)
	);

	// Stage 5: square the transmitted sine.
	logic         valid_s5;
	logic [59:0]  sq_s5;
	item_side_t   side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= st_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5   <= 60'(st) * 60'(st);
			side_s5 <= st_side;
		end
	end

	// Stage 6: one minus the squared sine, Q.60.
	logic         valid_s6;
	logic [60:0]  rad_s6;
	item_side_t   side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s6  <= (61'd1 << 60) - 61'(sq_s5);
			side_s6 <= side_s5;
		end
	end

	// Cosine of transmission, Q.30.
	logic              ct_valid;
	logic [TRIG_W-1:0] ct;
	item_side_t        ct_side;

	fdr_sqrt_pipe #(.RES_W(TRIG_W), .SIDE_W(SIDE_W)) u_sqrt_cos (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s6),
		.radicand({1'b0, rad_s6}),
		.in_side(side_s6),
		.out_valid(ct_valid), .root(ct), .out_side(ct_side)
	);

	// Stage 7: the four index products.
	logic              valid_s7, tir_s7;
	logic [30:0]       x1_s7, x2_s7;
	logic [PROD_W-1:0] y1_s7, y2_s7;
	logic [ETA_W-1:0]  ei7, et7;

	assign ei7 = ct_side.swap ? eta_trn_fix : eta_inc_fix;
	assign et7 = ct_side.swap ? eta_inc_fix : eta_trn_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= ct_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s7  <= 31'(et7) * 31'(ct_side.cmag);
			x2_s7  <= 31'(ei7) * 31'(ct_side.cmag);
			y1_s7  <= PROD_W'(ei7) * PROD_W'(ct);
			y2_s7  <= PROD_W'(et7) * PROD_W'(ct);
			tir_s7 <= ct_side.tir;
		end
	end

	// Stage 8: difference magnitudes and sums of each ratio.
	logic              valid_s8, tir_s8, dz1_s8, dz2_s8;
	logic [PROD_W-1:0] n1_s8, n2_s8, xa, xb;
	logic [DEN_W-1:0]  d1_s8, d2_s8;

	assign xa = PROD_W'(x1_s7) << 16;
	assign xb = PROD_W'(x2_s7) << 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s8  <= (xa > y1_s7) ? xa - y1_s7 : y1_s7 - xa;
			n2_s8  <= (xb > y2_s7) ? xb - y2_s7 : y2_s7 - xb;
			d1_s8  <= DEN_W'(xa) + DEN_W'(y1_s7);
			d2_s8  <= DEN_W'(xb) + DEN_W'(y2_s7);
			dz1_s8 <= (x1_s7 == '0) && (y1_s7 == '0);
			dz2_s8 <= (x2_s7 == '0) && (y2_s7 == '0);
			tir_s8 <= tir_s7;
		end
	end

	// Parallel and perpendicular amplitude ratios, Q.16.
	logic               r_valid, r_valid_b;
	logic [RATIO_W-1:0] q1, q2;
	logic [1:0]         r_side_a;
	logic               r_side_b;

	fdr_div_pipe #(.N_W(PROD_W + 16), .D_W(DEN_W), .Q_W(RATIO_W), .SIDE_W(2)) u_div_par (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s8), .dividend({n1_s8, 16'd0}), .divisor(d1_s8),
		.in_side({tir_s8, dz1_s8}),
		.out_valid(r_valid), .quotient(q1), .out_side(r_side_a)
	);

	fdr_div_pipe #(.N_W(PROD_W + 16), .D_W(DEN_W), .Q_W(RATIO_W), .SIDE_W(1)) u_div_perp (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s8), .dividend({n2_s8, 16'd0}), .divisor(d2_s8),
		.in_side(dz2_s8),
		.out_valid(r_valid_b), .quotient(q2), .out_side(r_side_b)
	);

	// Stage 9: square both ratios.
	logic               valid_s9, tir_s9;
	logic [33:0]        sq1_s9, sq2_s9;
	logic [RATIO_W-1:0] r1, r2;

	assign r1 = r_side_a[0] ? RATIO_ONE : q1;
	assign r2 = r_side_b    ? RATIO_ONE : q2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s9 <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s9 <= 34'(r1) * 34'(r1);
			sq2_s9 <= 34'(r2) * 34'(r2);
			tir_s9 <= r_side_a[1];
		end
	end

	// Stage 10: half-sum rounded to Q1.15, into the output register.
	logic [33:0] sum_rnd;
	assign sum_rnd = sq1_s9 + sq2_s9 + (34'd1 << 17);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			reflectance    <= tir_s9 ? REFL_ONE : sum_rnd[33:18];
			total_internal <= tir_s9;
		end
	end

`ifndef SYNTHESIS
	// Both ratio dividers run in lockstep.
	a_ratio_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid == r_valid_b)
		else $error("ratio dividers out of step");

	// Total internal reflection always reports exactly one.
	a_tir_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_internal |-> reflectance == REFL_ONE)
		else $error("total internal reflection without unit reflectance");

	// A held result is not overwritten by the next stage.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reflectance)
		&& $stable(total_internal))
		else $error("stalled result changed");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the Fresnel reflectance pipeline against a fixed-point predictor,
// using directed and random cosines under several index settings and
// random idling on both channels.
// ----------------------------------------------------------------------------

// Holds expected reflectance results in arrival order.
class refl_scoreboard;
	logic [15:0] exp_refl[$];
	logic        exp_tir[$];
	logic [15:0] eta_in;
	logic [15:0] eta_tr;
	int          errors;

	function new();
		eta_in = fdr_pkg::ETA_INCIDENT_RST;
		eta_tr = fdr_pkg::ETA_TRANSMITTED_RST;
		errors = 0;
	endfunction

	// Bitwise integer square root, floor.
	function logic [63:0] root(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Amplitude ratio |x - y| / (x + y) in Q.16.
	function logic [63:0] ratio(logic [63:0] x, logic [63:0] y);
		logic [63:0] n;
		logic [63:0] d;
		n = (x > y) ? x - y : y - x;
		d = x + y;
		if (d == 0)
			return 64'd65536;
		return (n << 16) / d;
	endfunction

	// Notes an accepted cosine and computes its reflectance.
	function void note_cosine(logic signed [15:0] cosv);
		int          c;
		logic [63:0] ei, et, t, cm, si, st, ct, ci, r1, r2, s;
		c = cosv;
		ei = (eta_in == 0) ? 1 : eta_in;
		et = (eta_tr == 0) ? 1 : eta_tr;
		if (c > 16384)
			c = 16384;
		if (c < -16384)
			c = -16384;
		if (c <= 0) begin
			t = ei;
			ei = et;
			et = t;
			cm = -c;
		end else begin
			cm = c;
		end
		si = root(((64'd1 << 28) - cm * cm) << 32);
		st = (ei * si) / et;
		if (st >= (64'd1 << 30)) begin
			exp_refl.push_back(fdr_pkg::REFL_ONE);
			exp_tir.push_back(1'b1);
			return;
		end
		ct = root((64'd1 << 60) - st * st);
		ci = cm << 16;
		r1 = ratio(et * ci, ei * ct);
		r2 = ratio(ei * ci, et * ct);
		s = r1 * r1 + r2 * r2;
		exp_refl.push_back(16'((s + (64'd1 << 17)) >> 18));
		exp_tir.push_back(1'b0);
	endfunction

	function void report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endfunction

	// Compares one output transfer with the oldest expectation.
	function void check_result(logic [15:0] refl, logic tir);
		logic [15:0] er;
		logic        et;
		if (exp_refl.size() == 0) begin
			report($sformatf("unexpected result %0d", refl));
			return;
		end
		er = exp_refl.pop_front();
		et = exp_tir.pop_front();
		if (refl !== er)
			report($sformatf("reflectance %0d, expected %0d", refl, er));
		if (tir !== et)
			report($sformatf("total_internal %b, expected %b", tir, et));
	endfunction
endclass

module tb;
	import fdr_pkg::*;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_stall;
	logic signed [15:0] cos_theta = 0;
	logic              out_valid;
	logic              out_stall = 0;
	logic [15:0]       reflectance;
	logic              total_internal;
	logic              cfg_valid = 0;
	logic              cfg_ready;
	cfg_reg_t          cfg_index = REG_ETA_INCIDENT;
	logic [15:0]       cfg_data = 0;

	int send_idle = 0;
	int recv_idle = 0;
	refl_scoreboard sb = new();

	fresnel_dielectric_reflectance dut (.*);

	always #1 clk = ~clk;

	// Receiver side: random stalls, checks each output transfer.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(reflectance, total_internal);
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Presents one cosine and waits for its transfer; valid stays high
	// for a following item unless the sender idles.
	task automatic send_cosine(logic signed [15:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cos_theta <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_cosine(v);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.exp_refl.size() != 0)
			@(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	// Writes one index register while the pipeline is empty.
	task automatic write_eta(cfg_reg_t idx, logic [15:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		if (idx == REG_ETA_INCIDENT)
			sb.eta_in = v;
		else
			sb.eta_tr = v;
		@(posedge clk);
	endtask

	// Random cosine, mostly in range, some beyond the clamp.
	function automatic logic signed [15:0] rand_cos();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'(16'($urandom_range(16400, 16360)) *
				($urandom_range(1) ? 1 : -1));
			default: return 16'sd16384 - 16'($urandom_range(32768));
		endcase
	endfunction

	initial begin
		logic [15:0] etas[6][2];
		etas = '{'{16'd4096, 16'd6144}, '{16'd6144, 16'd4096}, '{16'd1, 16'd65535},
			'{16'd65535, 16'd0}, '{16'd0, 16'd4096}, '{16'd5000, 16'd5461}};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, zero, clamp limits, near grazing.
		foreach (etas[k]) begin
			if (k > 0) begin
				write_eta(REG_ETA_INCIDENT, etas[k][0]);
				write_eta(REG_ETA_TRANSMITTED, etas[k][1]);
			end
			send_cosine(16'sd0);
			send_cosine(16'sd16384);
			send_cosine(-16'sd16384);
			send_cosine(16'sh7FFF);
			send_cosine(16'sh8000);
			send_cosine(16'sd1);
			send_cosine(-16'sd1);
			send_cosine(16'sd8192);
			send_cosine(-16'sd8192);
			send_cosine(16'sd16383);
			drain();
		end

		// Random phases with varied idling and random indices.
		for (int ph = 0; ph < 9; ph++) begin
			case (ph % 3)
				0: begin send_idle = 20; recv_idle = 71; end
				1: begin send_idle = 71; recv_idle = 20; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			write_eta(REG_ETA_INCIDENT, 16'($urandom_range(8192, 3000)));
			write_eta(REG_ETA_TRANSMITTED, ph == 4 ? 16'($urandom) :
				16'($urandom_range(8192, 3000)));
			for (int i = 0; i < 115; i++) begin
				send_cosine(rand_cos());
				if (i == 60) begin
					in_valid <= 0;
					while (sb.exp_refl.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
